// ===== rtl/krt_pkg.sv =====
// Package for the keyed record table: command and status codes, record type.
// Used by the interfaces, the cell chain and the top level.
package krt_pkg;
  localparam int DefaultDepth = 64;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_DELETE = 3'd1;
  localparam logic [2:0] CMD_UPDATE = 3'd2;
  localparam logic [2:0] CMD_LOOKUP = 3'd3;
  localparam logic [2:0] CMD_COUNT  = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic [15:0] key;
    logic [31:0] salary;
    logic [7:0]  sector;
    logic [7:0]  sex;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } rec_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] key;
    logic [31:0] salary_cents;
    logic [7:0]  sector_id;
    logic [7:0]  sex_code;
    logic [4:0]  birth_day;
    logic [3:0]  birth_month;
    logic [11:0] birth_year;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    rec_t        rec;
    logic [6:0]  sector_count;
  } rsp_t;

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) return c - 8'h20;
    return c;
  endfunction
endpackage

// ===== rtl/krt_cmd_if.sv =====
// Command channel: valid/ready handshake carrying one table command.
// Depends on krt_pkg.
interface krt_cmd_if;
  import krt_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/krt_rsp_if.sv =====
// Response channel: valid/ready handshake carrying one table result.
// Depends on krt_pkg.
interface krt_rsp_if;
  import krt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/krt_cell.sv =====
// One table slot: valid mark and record, plus the shift stage of the scan ring.
// Depends on krt_pkg.
module krt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,    // rotate the ring by one slot
  input  logic          wr_en,    // head cell only: write record
  input  logic          set_vld,
  input  logic          clr_vld,
  input  logic          upd_sal,
  input  krt_pkg::rec_t wr_rec,
  input  logic          prev_vld,
  input  krt_pkg::rec_t prev_rec,
  output logic          vld,
  output krt_pkg::rec_t rec
);
  import krt_pkg::*;

  logic vld_r, vld_nxt;
  rec_t rec_r, rec_nxt;

  always_comb begin
    vld_nxt = vld_r;
    rec_nxt = rec_r;
    if (shift) begin
      vld_nxt = prev_vld;
      rec_nxt = prev_rec;
    end else begin
      if (wr_en) rec_nxt = wr_rec;
      if (upd_sal) rec_nxt.salary = wr_rec.salary;
      if (set_vld) vld_nxt = 1'b1;
      if (clr_vld) vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else vld_r <= vld_nxt;
    rec_r <= rec_nxt;
  end

  assign vld = vld_r;
  assign rec = rec_r;
endmodule

// ===== rtl/krt_chain.sv =====
// Ring of krt_cell instances; cell 0 is the head that the control sees.
// Depends on krt_pkg and krt_cell.
module krt_chain #(
  parameter int TABLE_DEPTH = krt_pkg::DefaultDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  logic          wr_en,
  input  logic          set_vld,
  input  logic          clr_vld,
  input  logic          upd_sal,
  input  krt_pkg::rec_t wr_rec,
  output logic          head_vld,
  output krt_pkg::rec_t head_rec
);
  import krt_pkg::*;

  logic vld [TABLE_DEPTH];
  rec_t rec [TABLE_DEPTH];

  // Slot i sits at cell 0 after i rotations; rotating pulls from the next cell.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    localparam int Nx = (g + 1) % TABLE_DEPTH;
    krt_cell u_cell (
      .clk, .rst_n, .shift,
      .wr_en   (wr_en   && (g == 0)),
      .set_vld (set_vld && (g == 0)),
      .clr_vld (clr_vld && (g == 0)),
      .upd_sal (upd_sal && (g == 0)),
      .wr_rec,
      .prev_vld(vld[Nx]),
      .prev_rec(rec[Nx]),
      .vld     (vld[g]),
      .rec     (rec[g])
    );
  end

  assign head_vld = vld[0];
  assign head_rec = rec[0];
endmodule

// ===== rtl/keyed_record_table.sv =====
// Keyed record table: TABLE_DEPTH slots in a rotating ring of cells. A command is
// accepted only when the block is idle and no response waits. The first rotation
// scans for the lowest free slot, the key match and the sector count; the second
// stops at the chosen slot to read or modify it and brings slot 0 back home.
// Response is held in an output register; one command is in flight.
module keyed_record_table #(
  parameter int TABLE_DEPTH = krt_pkg::DefaultDepth
) (
  input  logic clk,
  input  logic rst_n,
  krt_cmd_if.sink   in_cmd,
  krt_rsp_if.source out_rsp
);
  import krt_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [IW-1:0] free_r, free_nxt, hit_r, hit_nxt;
  logic          has_free_r, has_free_nxt, has_hit_r, has_hit_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          act_r, act_nxt;
  cmd_t          cmd_r, cmd_nxt;
  rsp_t          rsp_r, rsp_nxt;
  logic          ovld_r, ovld_nxt;

  logic shift, wr_en, set_vld, clr_vld, upd_sal, head_vld;
  rec_t wr_rec, head_rec;
  logic [IW-1:0] target, pos_ix;

  assign pos_ix = pos_r[IW-1:0];
  assign target = (cmd_r.command == CMD_INSERT && !has_hit_r) ? free_r : hit_r;

  always_comb begin
    wr_rec.key    = cmd_r.key;
    wr_rec.salary = cmd_r.salary_cents;
    wr_rec.sector = cmd_r.sector_id;
    wr_rec.sex    = to_upper(cmd_r.sex_code);
    wr_rec.day    = cmd_r.birth_day;
    wr_rec.month  = cmd_r.birth_month;
    wr_rec.year   = cmd_r.birth_year;
  end

  krt_chain #(.TABLE_DEPTH(TABLE_DEPTH)) u_chain (
    .clk, .rst_n, .shift, .wr_en, .set_vld, .clr_vld, .upd_sal, .wr_rec,
    .head_vld, .head_rec
  );

  assign in_cmd.ready  = (state_r == S_IDLE) && !ovld_r;
  assign out_rsp.valid = ovld_r;
  assign out_rsp.data  = rsp_r;

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    free_nxt     = free_r;
    hit_nxt      = hit_r;
    has_free_nxt = has_free_r;
    has_hit_nxt  = has_hit_r;
    cnt_nxt      = cnt_r;
    act_nxt      = act_r;
    cmd_nxt      = cmd_r;
    rsp_nxt      = rsp_r;
    ovld_nxt     = ovld_r;
    shift = 1'b0; wr_en = 1'b0; set_vld = 1'b0; clr_vld = 1'b0; upd_sal = 1'b0;
    if (ovld_r && out_rsp.ready) ovld_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_cmd.valid && in_cmd.ready) begin
          cmd_nxt      = in_cmd.data;
          pos_nxt      = '0;
          has_free_nxt = 1'b0;
          has_hit_nxt  = 1'b0;
          cnt_nxt      = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        // examine head, then rotate
        if (!head_vld && !has_free_r) begin
          has_free_nxt = 1'b1;
          free_nxt     = pos_ix;
        end
        if (head_vld && head_rec.key == cmd_r.key && !has_hit_r) begin
          has_hit_nxt = 1'b1;
          hit_nxt     = pos_ix;
        end
        if (head_vld && head_rec.sector == cmd_r.sector_id && cnt_r != 7'd127)
          cnt_nxt = cnt_r + 7'd1;
        shift = 1'b1;
        if (pos_r == CW'(TABLE_DEPTH - 1)) begin
          pos_nxt   = '0;
          state_nxt = S_WALK;
        end else begin
          pos_nxt = pos_r + CW'(1);
        end
      end
      S_WALK: begin
        if (pos_r == '0) begin
          rsp_nxt = '0;
          act_nxt = 1'b0;
          case (cmd_r.command)
            CMD_INSERT: begin
              if (!has_free_r) rsp_nxt.status = ST_FULL;
              else begin
                rsp_nxt.status = has_hit_r ? ST_DUP : ST_OK;
                act_nxt = 1'b1;
              end
            end
            CMD_DELETE, CMD_UPDATE, CMD_LOOKUP: begin
              if (!has_hit_r) rsp_nxt.status = ST_MISS;
              else act_nxt = 1'b1;
            end
            CMD_COUNT: rsp_nxt.sector_count = cnt_r;
            default: ;
          endcase
        end
        if (act_r && pos_r != '0 || (pos_r == '0 && act_nxt)) begin
          if (pos_ix == target && pos_r != CW'(TABLE_DEPTH)) begin
            if (cmd_r.command == CMD_INSERT && !has_hit_r) begin
              wr_en = 1'b1; set_vld = 1'b1;
            end
            if (cmd_r.command == CMD_UPDATE) upd_sal = 1'b1;
            if (cmd_r.command == CMD_DELETE) clr_vld = 1'b1;
            act_nxt = 1'b0;
            state_nxt = S_DONE;
          end
        end
        if (state_nxt == S_WALK) begin
          shift = 1'b1;
          pos_nxt = pos_r + CW'(1);
          if (pos_r == CW'(TABLE_DEPTH - 1)) begin
            state_nxt = S_IDLE;
            ovld_nxt  = 1'b1;
          end
        end
      end
      S_DONE: begin
        // head holds the chosen slot after its modification
        rsp_nxt.slot = 6'(pos_r);
        rsp_nxt.rec  = head_rec;
        if (cmd_r.command == CMD_UPDATE) rsp_nxt.rec.salary = cmd_r.salary_cents;
        shift = 1'b1;
        if (pos_r == CW'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
          ovld_nxt  = 1'b1;
        end else begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = S_WALK;
          act_nxt   = 1'b0;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
      act_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
      act_r   <= act_nxt;
    end
    pos_r      <= pos_nxt;
    free_r     <= free_nxt;
    hit_r      <= hit_nxt;
    has_free_r <= has_free_nxt;
    has_hit_r  <= has_hit_nxt;
    cnt_r      <= cnt_nxt;
    cmd_r      <= cmd_nxt;
    rsp_r      <= rsp_nxt;
  end
endmodule

// ===== test/krt_tb_pkg.sv =====
`timescale 1ns / 100ps
// Testbench-side constants for the keyed record table bench.
// Depends on krt_pkg; used by the testbench top.
package krt_tb_pkg;
  import krt_pkg::*;
  localparam int TbDepth = 64;
  localparam int CmdCycles = 2 * TbDepth + 2;
endpackage

// ===== test/keyed_record_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench for keyed_record_table: drives table commands on the command channel,
// predicts each response with a behavioral table and checks field by field.
// Depends on krt_pkg, krt_tb_pkg, krt_cmd_if, krt_rsp_if and the RTL top.
module keyed_record_table_tb;
  import krt_pkg::*;
  import krt_tb_pkg::*;

  logic clk;
  logic rst_n;

  krt_cmd_if cmd_ch ();
  krt_rsp_if rsp_ch ();

  keyed_record_table #(.TABLE_DEPTH(TbDepth)) dut (
    .clk(clk), .rst_n(rst_n), .in_cmd(cmd_ch.sink), .out_rsp(rsp_ch.source)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // behavioral copy of the table
  logic       tbl_valid [TbDepth];
  rec_t       tbl_rec   [TbDepth];
  rsp_t       expected_rsps [$];
  logic [15:0] used_keys [$];

  int  fail_count;
  int  rsp_count;
  int  sent_count;
  int  idle_cycles;
  bit  src_idle_en;
  bit  sink_idle_en;
  int  hold_off;

  function automatic rsp_t predict_table(cmd_t c);
    rsp_t r;
    int free_slot;
    int hit;
    int cnt;
    logic [7:0] sx;
    r = '0;
    free_slot = -1;
    hit = -1;
    for (int i = 0; i < TbDepth; i++) begin
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
      if (tbl_valid[i] && tbl_rec[i].key == c.key && hit < 0) hit = i;
    end
    case (c.command)
      CMD_INSERT: begin
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else if (hit >= 0) begin
          r.status = ST_DUP;
          r.slot = hit[5:0];
          r.rec = tbl_rec[hit];
        end else begin
          sx = c.sex_code;
          if (sx >= 8'h61 && sx <= 8'h7A) sx = sx - 8'h20;
          tbl_rec[free_slot] = '{c.key, c.salary_cents, c.sector_id, sx,
                                 c.birth_day, c.birth_month, c.birth_year};
          tbl_valid[free_slot] = 1'b1;
          r.status = ST_OK;
          r.slot = free_slot[5:0];
          r.rec = tbl_rec[free_slot];
        end
      end
      CMD_DELETE, CMD_UPDATE, CMD_LOOKUP: begin
        if (hit < 0) begin
          r.status = ST_MISS;
        end else begin
          if (c.command == CMD_UPDATE) tbl_rec[hit].salary = c.salary_cents;
          r.status = ST_OK;
          r.slot = hit[5:0];
          r.rec = tbl_rec[hit];
          if (c.command == CMD_DELETE) tbl_valid[hit] = 1'b0;
        end
      end
      CMD_COUNT: begin
        cnt = 0;
        for (int i = 0; i < TbDepth; i++)
          if (tbl_valid[i] && tbl_rec[i].sector == c.sector_id && cnt < 127) cnt++;
        r.sector_count = cnt[6:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on response %0d: %s got %0h expected %0h", rsp_count, what, got, want);
    fail_count++;
  endtask

  // random burst of idle cycles on the sending side; valid stays up between
  // back-to-back beats and drops only while idling or draining
  task automatic send_cmd(cmd_t c);
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data <= c;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_rsps.push_back(predict_table(c));
    sent_count++;
  endtask

  function automatic cmd_t rand_cmd(logic [2:0] op);
    cmd_t c;
    c.command = op;
    c.key = ($urandom_range(0, 3) == 0 || used_keys.size() == 0) ? 16'($urandom)
            : used_keys[$urandom_range(0, used_keys.size() - 1)];
    c.salary_cents = $urandom;
    c.sector_id = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    c.sex_code = 8'($urandom);
    c.birth_day = 5'($urandom);
    c.birth_month = 4'($urandom);
    c.birth_year = 12'($urandom);
    if (op == CMD_INSERT) used_keys.push_back(c.key);
    if (used_keys.size() > 100) void'(used_keys.pop_front());
    return c;
  endfunction

  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
  endtask

  // response checker and receiver-side stalls
  always @(posedge clk) begin
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      rsp_t want;
      rsp_t got;
      got = rsp_ch.data;
      if (expected_rsps.size() == 0) begin
        $display("unexpected response %0d", rsp_count);
        fail_count++;
      end else begin
        want = expected_rsps.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.slot !== want.slot) report_mismatch("slot", got.slot, want.slot);
        if (got.rec.key !== want.rec.key) report_mismatch("key", got.rec.key, want.rec.key);
        if (got.rec.salary !== want.rec.salary)
          report_mismatch("salary", got.rec.salary, want.rec.salary);
        if (got.rec.sector !== want.rec.sector)
          report_mismatch("sector", got.rec.sector, want.rec.sector);
        if (got.rec.sex !== want.rec.sex) report_mismatch("sex", got.rec.sex, want.rec.sex);
        if (got.rec.day !== want.rec.day) report_mismatch("day", got.rec.day, want.rec.day);
        if (got.rec.month !== want.rec.month)
          report_mismatch("month", got.rec.month, want.rec.month);
        if (got.rec.year !== want.rec.year)
          report_mismatch("year", got.rec.year, want.rec.year);
        if (got.sector_count !== want.sector_count)
          report_mismatch("sector_count", got.sector_count, want.sector_count);
      end
      rsp_count++;
    end
  end

  int sink_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_off > 0) begin
      rsp_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (sink_gap > 0) begin
      rsp_ch.ready <= 1'b0;
      sink_gap <= sink_gap - 1;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      rsp_ch.ready <= 1'b0;
      sink_gap <= $urandom_range(0, 14);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20 * CmdCycles + 3000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_directed();
    cmd_t c;
    c = '{CMD_LOOKUP, 16'h1234, 32'h0, 8'h0, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    c = '{CMD_INSERT, 16'h0000, 32'h0, 8'h00, 8'h61, 5'h00, 4'h0, 12'h000};
    send_cmd(c);
    c = '{CMD_INSERT, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 8'h7A, 5'h1F, 4'hF, 12'hFFF};
    send_cmd(c);
    c = '{CMD_INSERT, 16'h0001, 32'h5555AAAA, 8'hFF, 8'h60, 5'h0A, 4'h5, 12'hAAA};
    send_cmd(c);
    c = '{CMD_INSERT, 16'h0002, 32'h1, 8'h01, 8'h7B, 5'h15, 4'hA, 12'h555};
    send_cmd(c);
    c = '{CMD_INSERT, 16'h0003, 32'h2, 8'h01, 8'hFF, 5'h01, 4'h1, 12'h7C0};
    send_cmd(c);
    c = '{CMD_INSERT, 16'hFFFF, 32'h7, 8'h2, 8'h41, 5'h2, 4'h2, 12'h2};
    send_cmd(c); // duplicate
    c = '{CMD_COUNT, 16'h0, 32'h0, 8'hFF, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    c = '{CMD_UPDATE, 16'h0001, 32'hDEADBEEF, 8'h0, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    c = '{CMD_LOOKUP, 16'h0001, 32'h0, 8'h0, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    c = '{CMD_DELETE, 16'h0000, 32'h0, 8'h0, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    c = '{CMD_DELETE, 16'h0000, 32'h0, 8'h0, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c); // miss
    c = '{CMD_UPDATE, 16'h4242, 32'h1, 8'h0, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    // freed slot 0 should be reused
    c = '{CMD_INSERT, 16'h0010, 32'h3, 8'h01, 8'h6D, 5'h3, 4'h3, 12'h3};
    send_cmd(c);
    c = '{CMD_COUNT, 16'h0, 32'h0, 8'h01, 8'h0, 5'h0, 4'h0, 12'h0};
    send_cmd(c);
    for (int op = 5; op <= 7; op++) begin
      c = '{3'(op), 16'hFFFF, 32'hFFFFFFFF, 8'hFF, 8'hFF, 5'h1F, 4'hF, 12'hFFF};
      send_cmd(c);
    end
    wait_drained();
  endtask

  // fill to full, then probe the full and duplicate order, then empty again
  task automatic test_full_table();
    cmd_t c;
    for (int i = 0; i < TbDepth + 3; i++) begin
      c = rand_cmd(CMD_INSERT);
      c.key = 16'(16'h8000 + i);
      send_cmd(c);
    end
    c = rand_cmd(CMD_INSERT);
    c.key = 16'h8000;
    send_cmd(c);
    c = rand_cmd(CMD_COUNT);
    send_cmd(c);
    for (int i = 0; i < TbDepth + 16; i++) begin
      c = rand_cmd(CMD_DELETE);
      c.key = (i < TbDepth) ? 16'(16'h8000 + i) : 16'($urandom);
      send_cmd(c);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 12; i++) send_cmd(rand_cmd(3'($urandom_range(0, 4))));
    wait_drained();
  endtask

  task automatic test_random(int n);
    logic [2:0] op;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40) op = CMD_INSERT;
      else if (r < 55) op = CMD_DELETE;
      else if (r < 70) op = CMD_UPDATE;
      else if (r < 85) op = CMD_LOOKUP;
      else if (r < 97) op = CMD_COUNT;
      else op = 3'($urandom_range(5, 7));
      send_cmd(rand_cmd(op));
      if (i == n / 2) wait_drained();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cmd_ch.valid = 1'b0;
    cmd_ch.data = '0;
    rsp_ch.ready = 1'b0;
    fail_count = 0;
    rsp_count = 0;
    sent_count = 0;
    idle_cycles = 0;
    hold_off = 0;
    src_idle_en = 1'b1;
    sink_idle_en = 1'b1;
    for (int i = 0; i < TbDepth; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rec[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random(1000);
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    test_random(200);
    wait_drained();
    repeat (2 * CmdCycles) @(posedge clk);
    $display("covered %0d commands: inserts to full, duplicates, deletes, updates,", sent_count);
    $display("lookups, sector counts and unused codes with stalls on both sides");
    if (fail_count == 0 && expected_rsps.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
